// File: hw/rtl/vertex_normal_averager_defines.svh
// Assertion macros used by the checker file.
`ifndef VERTEX_NORMAL_AVERAGER_DEFINES_SVH
`define VERTEX_NORMAL_AVERAGER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define VNA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vna assertion failed");

// Next-cycle implication, disabled in reset.
`define VNA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vna assertion failed");

`endif

// File: hw/rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal averager.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

    localparam int IDX_W    = 10;
    localparam int VERTICES = 1 << IDX_W;
    localparam int POS_W    = 16;
    localparam int NRM_W    = 16;
    localparam int ACC_W    = 24;
    localparam int VEC_W    = 35;

    localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
    localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]        read_index;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    status;
    } t_result;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
    } t_uvec;

    typedef struct packed {
        logic                    ok;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
    } t_ures;

endpackage

`default_nettype wire

// File: hw/rtl/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front
// Two-entry item queue between the input port and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  vna_pkg::t_item      i_item,
    output logic                o_full,
    output logic                o_valid,
    output vna_pkg::t_item      o_item,
    input  wire logic           i_pop
);

    vna_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vna_unit.sv
// ----------------------------------------------------------------------------
// vna_unit
// Iterative unit-length scaler: pre-shift, sum of squares, bit-serial
// square root and restoring division, result in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  vna_pkg::t_uvec  i_vec,
    output logic            o_done,
    output vna_pkg::t_ures  o_res
);

    typedef enum logic [3:0] {
        U_IDLE, U_SHIFT, U_SQ, U_CHK, U_SQRT, U_DSET, U_DIV, U_STORE, U_DONE
    } t_ustate;

    t_ustate                          r_state;
    logic [vna_pkg::VEC_W-1:0]        r_m [3];
    logic [2:0]                       r_neg;
    logic [3:0]                       r_cnt;
    logic [1:0]                       r_comp;
    logic [61:0]                      r_prod;
    logic [63:0]                      r_sum;
    logic [63:0]                      r_v;
    logic [63:0]                      r_r;
    logic [63:0]                      r_bit;
    logic [45:0]                      r_num;
    logic [14:0]                      r_q;
    logic                             r_done;
    vna_pkg::t_ures                   r_res;

    logic [vna_pkg::VEC_W-1:0]        w_msq;
    logic [vna_pkg::VEC_W-1:0]        w_mdv;
    logic [63:0]                      w_trial;
    logic [45:0]                      w_dsh;
    logic signed [vna_pkg::NRM_W-1:0] w_nq;
    logic                             w_big;

    assign o_done = r_done;
    assign o_res  = r_res;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_msq = r_m[0];
            2'd1:    w_msq = r_m[1];
            default: w_msq = r_m[2];
        endcase
        case (r_comp)
            2'd0:    w_mdv = r_m[0];
            2'd1:    w_mdv = r_m[1];
            default: w_mdv = r_m[2];
        endcase
        w_trial = r_r + r_bit;
        w_dsh   = 46'(r_r[31:0]) << r_cnt;
        w_nq    = r_neg[r_comp] ? -16'(r_q) : 16'(r_q);
        w_big   = (r_m[0][34:31] != 4'd0) || (r_m[1][34:31] != 4'd0)
               || (r_m[2][34:31] != 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_m[0]  <= i_vec.x[34] ? 35'(-i_vec.x) : 35'(i_vec.x);
                        r_m[1]  <= i_vec.y[34] ? 35'(-i_vec.y) : 35'(i_vec.y);
                        r_m[2]  <= i_vec.z[34] ? 35'(-i_vec.z) : 35'(i_vec.z);
                        r_neg   <= {i_vec.z[34], i_vec.y[34], i_vec.x[34]};
                        r_state <= U_SHIFT;
                    end
                end
                U_SHIFT: begin
                    if (w_big) begin
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else begin
                        r_cnt   <= 4'd0;
                        r_sum   <= 64'd0;
                        r_state <= U_SQ;
                    end
                end
                U_SQ: begin
                    if (r_cnt != 4'd0) begin
                        r_sum <= r_sum + 64'(r_prod);
                    end
                    if (r_cnt != 4'd3) begin
                        r_prod <= w_msq[30:0] * w_msq[30:0];
                        r_cnt  <= r_cnt + 4'd1;
                    end else begin
                        r_state <= U_CHK;
                    end
                end
                U_CHK: begin
                    if (r_sum == 64'd0) begin
                        r_res   <= '0;
                        r_state <= U_DONE;
                    end else begin
                        r_v     <= r_sum;
                        r_r     <= 64'd0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= U_SQRT;
                    end
                end
                U_SQRT: begin
                    if (r_v >= w_trial) begin
                        r_v <= r_v - w_trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_comp  <= 2'd0;
                        r_state <= U_DSET;
                    end
                end
                U_DSET: begin
                    r_num   <= 46'({w_mdv[30:0], 14'd0}) + 46'(r_r[31:1]);
                    r_q     <= 15'd0;
                    r_cnt   <= 4'd14;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    if (r_num >= w_dsh) begin
                        r_num        <= r_num - w_dsh;
                        r_q[r_cnt]   <= 1'b1;
                    end
                    if (r_cnt == 4'd0) begin
                        r_state <= U_STORE;
                    end else begin
                        r_cnt <= r_cnt - 4'd1;
                    end
                end
                U_STORE: begin
                    case (r_comp)
                        2'd0:    r_res.nx <= w_nq;
                        2'd1:    r_res.ny <= w_nq;
                        default: r_res.nz <= w_nq;
                    endcase
                    if (r_comp == 2'd2) begin
                        r_res.ok <= 1'b1;
                        r_state  <= U_DONE;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= U_DSET;
                    end
                end
                U_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vna_core.sv
// ----------------------------------------------------------------------------
// vna_core
// Back-end sequencer: position and accumulator memories, cross product,
// saturating accumulate, clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  vna_pkg::t_item      i_item,
    output logic                o_item_pop,
    output logic                o_init_busy,
    output logic                o_rslt_push,
    output vna_pkg::t_result    o_rslt,
    input  wire logic           i_rslt_full,
    output logic                o_unit_start,
    output vna_pkg::t_uvec      o_unit_vec,
    input  wire logic           i_unit_done,
    input  vna_pkg::t_ures      i_unit_res
);

    typedef enum logic [3:0] {
        C_CLEAR, C_IDLE, C_TRI_RA, C_TRI_RB, C_TRI_RC, C_TRI_D, C_MUL,
        C_CROSS, C_RD_A, C_RD_B, C_START, C_WAIT, C_ACC_RD, C_ACC_WR, C_OUT
    } t_cstate;

    localparam int AW = 3 * vna_pkg::ACC_W;
    localparam int PW = 3 * vna_pkg::POS_W;

    logic [PW-1:0]                   r_pos_mem [vna_pkg::VERTICES];
    logic [AW-1:0]                   r_acc_mem [vna_pkg::VERTICES];
    logic [PW-1:0]                   r_pos_rd;
    logic [AW-1:0]                   r_acc_rd;

    t_cstate                         r_state;
    logic                            r_init;
    logic [vna_pkg::IDX_W-1:0]       r_clr;
    vna_pkg::t_item                  r_item;
    logic                            r_is_tri;
    logic [2:0]                      r_k;
    logic [PW-1:0]                   r_pa;
    logic [PW-1:0]                   r_pb;
    logic signed [16:0]              r_ux, r_uy, r_uz, r_wx, r_wy, r_wz;
    logic signed [33:0]              r_p [6];
    vna_pkg::t_uvec                  r_cr;
    vna_pkg::t_ures                  r_res;

    logic                            w_pos_we;
    logic [vna_pkg::IDX_W-1:0]       w_pos_ra;
    logic [vna_pkg::IDX_W-1:0]       w_acc_a;
    logic                            w_acc_we;
    logic [AW-1:0]                   w_acc_wd;
    logic [vna_pkg::IDX_W-1:0]       w_corner;
    logic signed [16:0]              w_ma, w_mb;
    logic signed [vna_pkg::ACC_W-1:0] w_sx, w_sy, w_sz;

    function automatic logic signed [16:0] f_diff(input logic [15:0] p, input logic [15:0] q);
        return $signed({p[15], p}) - $signed({q[15], q});
    endfunction

    function automatic logic signed [vna_pkg::ACC_W-1:0] f_sat(
        input logic [vna_pkg::ACC_W-1:0] acc, input logic signed [vna_pkg::NRM_W-1:0] d);
        logic signed [vna_pkg::ACC_W:0] s;
        s = 25'($signed(acc)) + 25'(d);
        if (s > vna_pkg::ACC_MAX) s = vna_pkg::ACC_MAX;
        if (s < vna_pkg::ACC_MIN) s = vna_pkg::ACC_MIN;
        return s[vna_pkg::ACC_W-1:0];
    endfunction

    assign o_item_pop   = (r_state == C_IDLE) && i_item_valid;
    assign o_init_busy  = r_init;
    assign o_unit_start = (r_state == C_START);
    assign o_unit_vec   = r_cr;
    assign o_rslt_push  = (r_state == C_OUT) && !i_rslt_full;
    assign o_rslt       = '{read_index: r_item.vertex_index, normal_x: r_res.nx,
                            normal_y: r_res.ny, normal_z: r_res.nz, status: !r_res.ok};

    always_comb begin
        case (r_k[1:0])
            2'd0:    w_corner = r_item.corner_a;
            2'd1:    w_corner = r_item.corner_b;
            default: w_corner = r_item.corner_c;
        endcase
        case (r_state)
            C_TRI_RA: w_pos_ra = r_item.corner_a;
            C_TRI_RB: w_pos_ra = r_item.corner_b;
            default:  w_pos_ra = r_item.corner_c;
        endcase
        case (r_state)
            C_CLEAR:  w_acc_a = r_clr;
            C_RD_A:   w_acc_a = r_item.vertex_index;
            default:  w_acc_a = w_corner;
        endcase
        case (r_k)
            3'd0:    begin w_ma = r_uy; w_mb = r_wz; end
            3'd1:    begin w_ma = r_uz; w_mb = r_wy; end
            3'd2:    begin w_ma = r_uz; w_mb = r_wx; end
            3'd3:    begin w_ma = r_ux; w_mb = r_wz; end
            3'd4:    begin w_ma = r_ux; w_mb = r_wy; end
            default: begin w_ma = r_uy; w_mb = r_wx; end
        endcase
        w_sx     = f_sat(r_acc_rd[71:48], r_res.nx);
        w_sy     = f_sat(r_acc_rd[47:24], r_res.ny);
        w_sz     = f_sat(r_acc_rd[23:0],  r_res.nz);
        w_pos_we = o_item_pop && (i_item.op == vna_pkg::OP_WRITE);
        w_acc_we = (r_state == C_CLEAR) || (r_state == C_ACC_WR);
        w_acc_wd = (r_state == C_CLEAR) ? '0 : {w_sx, w_sy, w_sz};
    end

    // position memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[i_item.vertex_index] <= {i_item.pos_x, i_item.pos_y, i_item.pos_z};
        end
        r_pos_rd <= r_pos_mem[w_pos_ra];
    end

    // accumulator memory: read and write share the address
    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_a] <= w_acc_wd;
        end
        r_acc_rd <= r_acc_mem[w_acc_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_CLEAR;
            r_init  <= 1'b1;
            r_clr   <= '0;
        end else begin
            case (r_state)
                C_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == vna_pkg::IDX_W'(vna_pkg::VERTICES - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= C_IDLE;
                    end
                end
                C_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                        case (i_item.op)
                            vna_pkg::OP_TRI:   r_state <= C_TRI_RA;
                            vna_pkg::OP_READ:  r_state <= C_RD_A;
                            vna_pkg::OP_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= C_CLEAR;
                            end
                            default:           r_state <= C_IDLE;
                        endcase
                    end
                end
                C_TRI_RA: r_state <= C_TRI_RB;
                C_TRI_RB: begin
                    r_pa    <= r_pos_rd;
                    r_state <= C_TRI_RC;
                end
                C_TRI_RC: begin
                    r_pb    <= r_pos_rd;
                    r_state <= C_TRI_D;
                end
                C_TRI_D: begin
                    r_ux    <= f_diff(r_pb[47:32], r_pa[47:32]);
                    r_uy    <= f_diff(r_pb[31:16], r_pa[31:16]);
                    r_uz    <= f_diff(r_pb[15:0],  r_pa[15:0]);
                    r_wx    <= f_diff(r_pos_rd[47:32], r_pa[47:32]);
                    r_wy    <= f_diff(r_pos_rd[31:16], r_pa[31:16]);
                    r_wz    <= f_diff(r_pos_rd[15:0],  r_pa[15:0]);
                    r_k     <= 3'd0;
                    r_state <= C_MUL;
                end
                C_MUL: begin
                    r_p[r_k] <= w_ma * w_mb;
                    if (r_k == 3'd5) begin
                        r_state <= C_CROSS;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                C_CROSS: begin
                    r_cr.x   <= 35'(r_p[0]) - 35'(r_p[1]);
                    r_cr.y   <= 35'(r_p[2]) - 35'(r_p[3]);
                    r_cr.z   <= 35'(r_p[4]) - 35'(r_p[5]);
                    r_is_tri <= 1'b1;
                    r_state  <= C_START;
                end
                C_RD_A: r_state <= C_RD_B;
                C_RD_B: begin
                    r_cr.x   <= 35'($signed(r_acc_rd[71:48]));
                    r_cr.y   <= 35'($signed(r_acc_rd[47:24]));
                    r_cr.z   <= 35'($signed(r_acc_rd[23:0]));
                    r_is_tri <= 1'b0;
                    r_state  <= C_START;
                end
                C_START: r_state <= C_WAIT;
                C_WAIT: begin
                    if (i_unit_done) begin
                        r_res <= i_unit_res;
                        r_k   <= 3'd0;
                        r_state <= r_is_tri ? C_ACC_RD : C_OUT;
                    end
                end
                C_ACC_RD: r_state <= C_ACC_WR;
                C_ACC_WR: begin
                    if (r_k == 3'd2) begin
                        r_state <= C_IDLE;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= C_ACC_RD;
                    end
                end
                C_OUT: begin
                    if (!i_rslt_full) begin
                        r_state <= C_IDLE;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vna_rslt.sv
// ----------------------------------------------------------------------------
// vna_rslt
// Two-entry result queue in front of the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_rslt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  vna_pkg::t_result    i_rslt,
    output logic                o_full,
    output logic                o_empty,
    output vna_pkg::t_result    o_rslt,
    input  wire logic           i_pop
);

    vna_pkg::t_result r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rslt  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_rslt;
                r_wp        <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/vertex_normal_averager.sv
// ----------------------------------------------------------------------------
// vertex_normal_averager
// Smoothed per-vertex normals of a triangle mesh in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue: drive an item and raise push; it is taken on an edge where
//    full is low. Ops: write position, add triangle, read normal, clear.
//  - Result queue: only reads answer. While empty is low the oldest normal
//    sits on the o_ ports; pop on an edge with empty low takes it.
//  - Items are run one at a time by the single back-end sequencer and its
//    iterative scaler (1-bit/cycle square root, 15-step division per axis);
//    a new item is taken only once the last is done. Adding a triangle may
//    pre-shift a large cross product; clear zeroes one row per cycle.
//  - Reset: synchronous, active low. Afterwards the accumulators are swept
//    to zero with full held high; positions are undefined until written.
//  - A stalled receiver fills the two-entry result queue; the sequencer then
//    waits on its result and the two-entry input queue fills, raising full.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_averager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_op,
    input  wire logic [9:0]  i_vertex_index,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic signed [15:0] i_pos_z,
    input  wire logic [9:0]  i_corner_a,
    input  wire logic [9:0]  i_corner_b,
    input  wire logic [9:0]  i_corner_c,
    output logic             empty,
    input  wire logic        pop,
    output logic [9:0]       o_read_index,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic             o_status
);

    vna_pkg::t_item   w_in_item;
    vna_pkg::t_item   w_q_item;
    logic             w_q_valid;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_init_busy;
    logic             w_r_push;
    logic             w_r_full;
    vna_pkg::t_result w_r_in;
    vna_pkg::t_result w_r_out;
    logic             w_u_start;
    logic             w_u_done;
    vna_pkg::t_uvec   w_u_vec;
    vna_pkg::t_ures   w_u_res;

    // hold off items while the post-reset clear sweep runs
    assign full = w_q_full | w_init_busy;

    assign w_in_item = '{op: vna_pkg::t_op'(i_op), vertex_index: i_vertex_index,
                         pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                         corner_a: i_corner_a, corner_b: i_corner_b,
                         corner_c: i_corner_c};

    vna_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_item  (w_in_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    vna_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_item_pop   (w_q_pop),
        .o_init_busy  (w_init_busy),
        .o_rslt_push  (w_r_push),
        .o_rslt       (w_r_in),
        .i_rslt_full  (w_r_full),
        .o_unit_start (w_u_start),
        .o_unit_vec   (w_u_vec),
        .i_unit_done  (w_u_done),
        .i_unit_res   (w_u_res)
    );

    vna_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_u_start),
        .i_vec   (w_u_vec),
        .o_done  (w_u_done),
        .o_res   (w_u_res)
    );

    vna_rslt u_rslt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_r_push),
        .i_rslt  (w_r_in),
        .o_full  (w_r_full),
        .o_empty (empty),
        .o_rslt  (w_r_out),
        .i_pop   (pop)
    );

    assign o_read_index = w_r_out.read_index;
    assign o_normal_x   = w_r_out.normal_x;
    assign o_normal_y   = w_r_out.normal_y;
    assign o_normal_z   = w_r_out.normal_z;
    assign o_status     = w_r_out.status;

endmodule

`default_nettype wire

// File: hw/rtl/vna_chk.sv
// ----------------------------------------------------------------------------
// vna_chk
// Port-level checks of the vertex normal averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_normal_averager_defines.svh"

module vna_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [9:0]  o_read_index,
    input wire logic signed [15:0] o_normal_x,
    input wire logic signed [15:0] o_normal_y,
    input wire logic signed [15:0] o_normal_z,
    input wire logic        o_status
);

    // zero-length flag comes with an all-zero normal
    `VNA_ASSERT_IMP(a_status_zero, i_clk, i_rst_n, !empty && o_status, o_normal_x == 16'sd0 && o_normal_y == 16'sd0 && o_normal_z == 16'sd0)
    // the x and z components stay within unit range
    `VNA_ASSERT_IMP(a_unit_range, i_clk, i_rst_n, !empty, o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384 && o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384)
    // clear sweep after reset blocks input, result queue starts empty
    `VNA_ASSERT_IMP(a_reset_full, i_clk, i_rst_n, !$past(i_rst_n), full && empty)
    // a stalled result holds
    `VNA_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_read_index))

endmodule

bind vertex_normal_averager vna_chk u_vna_chk (.*);

`default_nettype wire
